### rtl/msd_pkg.sv
// Package for the motion session detector.
// Holds event codes, register indexes, reset values and the flag struct.
// No dependencies.
package msd_pkg;

  localparam int TIME_W = 32;
  localparam int THR_W  = 16;
  localparam int CFG_W  = 32;

  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t CFG_THRESHOLD = 1'b0;
  localparam cfg_index_t CFG_TIMEOUT   = 1'b1;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd1000;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET   = 32'd10000;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_END   = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic motion;
    logic start;
    logic finish;
  } msd_flags_t;

endpackage

### rtl/msd_step.sv
// Combinational evaluation of one sample against the session state.
// Produces the next state and the event flags; depends on msd_pkg.
module msd_step #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TOTAL_WIDTH  = 40
) (
  input  logic [SAMPLE_WIDTH-1:0]       sample,
  input  logic [SAMPLE_WIDTH-1:0]       prev_sample,
  input  logic [msd_pkg::TIME_W-1:0]    now_ms,
  input  logic [msd_pkg::THR_W-1:0]     threshold,
  input  logic [msd_pkg::TIME_W-1:0]    timeout,
  input  logic                          session_on,
  input  logic [TOTAL_WIDTH-1:0]        running_total,
  input  logic [msd_pkg::TIME_W-1:0]    last_motion,
  output msd_pkg::msd_flags_t           flags,
  output logic                          session_nxt,
  output logic [TOTAL_WIDTH-1:0]        total_nxt,
  output logic [msd_pkg::TIME_W-1:0]    last_nxt
);

  localparam int CMP_W = (SAMPLE_WIDTH > msd_pkg::THR_W) ? SAMPLE_WIDTH : msd_pkg::THR_W;
  localparam int SUM_W = ((TOTAL_WIDTH > SAMPLE_WIDTH) ? TOTAL_WIDTH : SAMPLE_WIDTH) + 1;

  logic signed [SAMPLE_WIDTH:0]  delta;
  logic        [SAMPLE_WIDTH:0]  delta_abs;
  logic        [SAMPLE_WIDTH-1:0] diff;
  logic                          motion;
  logic                          start;
  logic        [TOTAL_WIDTH-1:0] base;
  logic        [SUM_W-1:0]       sum;
  logic                          sat;
  logic                          active;
  logic        [msd_pkg::TIME_W-1:0] idle;
  logic                          finish;

  always_comb begin
    delta     = $signed({sample[SAMPLE_WIDTH-1], sample})
              - $signed({prev_sample[SAMPLE_WIDTH-1], prev_sample});
    delta_abs = delta[SAMPLE_WIDTH] ? (~delta + 1'b1) : delta;
    diff      = delta_abs[SAMPLE_WIDTH-1:0];
    motion    = CMP_W'(diff) > CMP_W'(threshold);
    start     = motion && !session_on;
    base      = start ? '0 : running_total;
    sum       = SUM_W'(base) + SUM_W'(diff);
    sat       = |sum[SUM_W-1:TOTAL_WIDTH];
    total_nxt = motion ? (sat ? {TOTAL_WIDTH{1'b1}} : sum[TOTAL_WIDTH-1:0]) : running_total;
    last_nxt  = motion ? now_ms : last_motion;
    active    = session_on || motion;
    idle      = now_ms - last_nxt;
    finish    = active && (idle > timeout);
    session_nxt  = active && !finish;
    flags.motion = motion;
    flags.start  = start;
    flags.finish = finish;
  end

endmodule

### rtl/motion_session_detector.sv
// Top level of the motion session detector: stream ports, registers, config.
// Depends on msd_pkg and msd_step.
//
// One item enters per clock unless a stalled output register holds the input.
// An accepted sample is held in the input register, evaluated against the
// session state in a single pass, and its event, if any, lands in the output
// register; the sustained rate is one item per cycle, set by the loop through
// the session state registers. A start event carries a total of zero; an end
// event carries the saturated sum of the session.
module motion_session_detector #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TOTAL_WIDTH  = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0 up: sample_value, now_ms, zero fill.
  input  logic [((SAMPLE_WIDTH+msd_pkg::TIME_W+7)/8)*8-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // Fields from bit 0 up: motion_total, event_time_ms, zero fill.
  output logic [((TOTAL_WIDTH+msd_pkg::TIME_W+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0 up: event_kind.
  output logic                        out_tuser,
  input  logic                        cfg_we,
  input  msd_pkg::cfg_index_t         cfg_index,
  input  logic [msd_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int OUT_W = ((TOTAL_WIDTH + msd_pkg::TIME_W + 7) / 8) * 8;

  logic [msd_pkg::THR_W-1:0]  threshold_r;
  logic [msd_pkg::TIME_W-1:0] timeout_r;

  logic                       s1_valid_r;
  logic [SAMPLE_WIDTH-1:0]    s1_sample_r;
  logic [msd_pkg::TIME_W-1:0] s1_now_r;

  logic [SAMPLE_WIDTH-1:0]    prev_sample_r;
  logic                       session_on_r;
  logic [TOTAL_WIDTH-1:0]     total_r;
  logic [msd_pkg::TIME_W-1:0] last_motion_r;

  logic                       out_valid_r;
  msd_pkg::event_kind_t       out_kind_r;
  logic [TOTAL_WIDTH-1:0]     out_total_r;
  logic [msd_pkg::TIME_W-1:0] out_time_r;

  msd_pkg::msd_flags_t        flags;
  logic                       session_nxt;
  logic [TOTAL_WIDTH-1:0]     total_nxt;
  logic [msd_pkg::TIME_W-1:0] last_nxt;
  logic                       proc;
  logic                       in_fire;

  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  msd_step #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_step (
    .sample       (s1_sample_r),
    .prev_sample  (prev_sample_r),
    .now_ms       (s1_now_r),
    .threshold    (threshold_r),
    .timeout      (timeout_r),
    .session_on   (session_on_r),
    .running_total(total_r),
    .last_motion  (last_motion_r),
    .flags        (flags),
    .session_nxt  (session_nxt),
    .total_nxt    (total_nxt),
    .last_nxt     (last_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= msd_pkg::THRESHOLD_RESET;
      timeout_r   <= msd_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        msd_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata[msd_pkg::THR_W-1:0];
        msd_pkg::CFG_TIMEOUT:   timeout_r   <= cfg_wdata[msd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_fire) begin
      s1_sample_r <= in_tdata[SAMPLE_WIDTH-1:0];
      s1_now_r    <= in_tdata[SAMPLE_WIDTH+msd_pkg::TIME_W-1:SAMPLE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      session_on_r  <= 1'b0;
      total_r       <= '0;
      last_motion_r <= '0;
    end else if (proc) begin
      prev_sample_r <= s1_sample_r;
      session_on_r  <= session_nxt;
      total_r       <= total_nxt;
      last_motion_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= flags.start || flags.finish;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (proc) begin
      out_kind_r  <= flags.finish ? msd_pkg::KIND_END : msd_pkg::KIND_START;
      out_total_r <= flags.finish ? total_r : '0;
      out_time_r  <= s1_now_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = OUT_W'({out_time_r, out_total_r});

  a_start_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == msd_pkg::KIND_START) |-> (out_total_r == '0))
    else $error("start event carries a nonzero total");

  a_rise_emits_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(session_on_r) |-> (out_valid_r && out_kind_r == msd_pkg::KIND_START))
    else $error("session opened without a start event");

  a_fall_emits_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(session_on_r) |-> (out_valid_r && out_kind_r == msd_pkg::KIND_END
                             && out_total_r == total_r))
    else $error("session closed without a matching end event");

  a_end_needs_session: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && flags.finish) |-> (session_on_r || flags.motion) && !flags.start)
    else $error("end event without an active session");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for motion_session_detector: a directed table, then random phases
// under several threshold and timeout settings, each event checked against the table or a session tracker.
// Depends on msd_pkg and the detector RTL.
module testbench;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W = 40;
  localparam int IN_W = 48;
  localparam int OUT_W = 72;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam int N_ROWS = 15;
  localparam int N_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    msd_pkg::event_kind_t kind;
    logic [TOTAL_W-1:0] total;
    logic [msd_pkg::TIME_W-1:0] stamp;
  } session_event_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [msd_pkg::TIME_W-1:0] stamp;
    logic typed;
    session_event_t want;
  } stim_row_t;

  localparam session_event_t NO_EVENT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  msd_pkg::cfg_index_t cfg_index = msd_pkg::CFG_THRESHOLD;
  logic [msd_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Session tracker state and its copy of the registers.
  logic [SAMPLE_W-1:0] prev_sample_q = '0;
  bit session_open = 1'b0;
  logic [TOTAL_W-1:0] motion_sum = '0;
  logic [msd_pkg::TIME_W-1:0] last_motion_ms = '0;
  logic [msd_pkg::THR_W-1:0] cur_threshold = msd_pkg::THRESHOLD_RESET;
  logic [msd_pkg::TIME_W-1:0] cur_timeout = msd_pkg::TIMEOUT_RESET;

  session_event_t pending_events[$];
  int mismatch_count = 0;
  int events_seen = 0;
  logic [SAMPLE_W-1:0] last_sample = '0;
  logic [msd_pkg::TIME_W-1:0] clock_ms = '0;

  motion_session_detector u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void advance_session(input logic [SAMPLE_W-1:0] sample,
                                          input logic [msd_pkg::TIME_W-1:0] stamp,
                                          output bit fired, output session_event_t ev);
    int delta;
    logic [16:0] diff;
    logic [msd_pkg::TIME_W-1:0] idle;
    fired = 1'b0;
    ev = NO_EVENT;
    delta = int'($signed(sample)) - int'($signed(prev_sample_q));
    diff = (delta < 0) ? 17'(-delta) : 17'(delta);
    prev_sample_q = sample;
    if (diff > {1'b0, cur_threshold}) begin
      if (!session_open) begin
        session_open = 1'b1;
        motion_sum = '0;
        fired = 1'b1;
        ev.kind = msd_pkg::KIND_START;
        ev.total = '0;
        ev.stamp = stamp;
      end
      if (TOTAL_W'(diff) > TOTAL_MAX - motion_sum) begin
        motion_sum = TOTAL_MAX;
      end else begin
        motion_sum = motion_sum + TOTAL_W'(diff);
      end
      last_motion_ms = stamp;
    end
    idle = stamp - last_motion_ms;
    if (session_open && idle > cur_timeout) begin
      session_open = 1'b0;
      fired = 1'b1;
      ev.kind = msd_pkg::KIND_END;
      ev.total = motion_sum;
      ev.stamp = stamp;
    end
  endfunction

  task automatic offer_sample(input logic [SAMPLE_W-1:0] sample,
                              input logic [msd_pkg::TIME_W-1:0] stamp,
                              input bit typed, input session_event_t want);
    bit fired;
    session_event_t ev;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {stamp, sample};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_session(sample, stamp, fired, ev);
    if (typed) begin
      pending_events.push_back(want);
    end else if (fired) begin
      pending_events.push_back(ev);
    end
    last_sample = sample;
  endtask

  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Stops offering items until every pending event has come back and the pipeline is empty.
  task automatic wait_drained();
    pause_input(1);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input msd_pkg::cfg_index_t idx,
                               input logic [msd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == msd_pkg::CFG_THRESHOLD) begin
      cur_threshold = val[msd_pkg::THR_W-1:0];
    end else begin
      cur_timeout = val;
    end
  endtask

  task automatic offer_random_sample();
    int pick;
    logic [SAMPLE_W-1:0] next_sample;
    logic [SAMPLE_W-1:0] step;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      clock_ms = clock_ms + $urandom_range(0, 20);
    end else if (pick < 8) begin
      clock_ms = clock_ms + cur_timeout + $urandom_range(0, 2) - 1;
    end else if (pick < 9) begin
      clock_ms = clock_ms + $urandom_range(0, 1000);
    end else begin
      clock_ms = $urandom;
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      next_sample = SAMPLE_W'($urandom);
    end else if (pick < 7) begin
      step = SAMPLE_W'(cur_threshold + $urandom_range(0, 2) - 1);
      next_sample = ($urandom_range(0, 1) == 1) ? last_sample + step : last_sample - step;
    end else begin
      next_sample = SAMPLE_W'(last_sample + $urandom_range(0, 15) - 8);
    end
    offer_sample(next_sample, clock_ms, 1'b0, NO_EVENT);
  endtask

  always @(posedge clk) begin : check_results
    session_event_t got;
    session_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = msd_pkg::event_kind_t'(out_tuser);
      got.total = out_tdata[TOTAL_W-1:0];
      got.stamp = out_tdata[TOTAL_W +: msd_pkg::TIME_W];
      events_seen++;
      if (pending_events.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected event: kind %0d total %0d time %0d",
                   got.kind, got.total, got.stamp);
        end
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (got.kind != want.kind || got.total != want.total || got.stamp != want.stamp) begin
          if (mismatch_count < 10) begin
            $display("event mismatch: kind %0d/%0d total %0d/%0d time %0d/%0d (expected/actual)",
                     want.kind, got.kind, want.total, got.total, want.stamp, got.stamp);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: shifting stall patterns, plus one long hold-off once traffic is flowing.
  always @(negedge clk) begin : drive_ready
    int hold_left;
    bit hold_done;
    int mode;
    int mode_left;
    bit ready_now;
    if (hold_left > 0) begin
      hold_left--;
      ready_now = 1'b0;
    end else if (!hold_done && events_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      ready_now = 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        0: ready_now = 1'b1;
        1: ready_now = ($urandom_range(0, 1) == 1);
        default: ready_now = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_tready <= ready_now;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t rows[N_ROWS];
    logic [msd_pkg::THR_W-1:0] thr_set[N_PHASES];
    logic [msd_pkg::TIME_W-1:0] tmo_set[N_PHASES];
    int burst_left;
    rows = '{
      '{16'hFC18, 32'd0,         1'b0, NO_EVENT},
      '{16'hFC18, 32'd10,        1'b0, NO_EVENT},
      '{16'd1001,  32'd20,        1'b1, '{msd_pkg::KIND_START, 40'd0, 32'd20}},
      '{16'h7FFF, 32'd30,        1'b0, NO_EVENT},
      '{16'h8000, 32'd40,        1'b0, NO_EVENT},
      '{16'h8000, 32'd10040,     1'b0, NO_EVENT},
      '{16'h8000, 32'd10041,     1'b1, '{msd_pkg::KIND_END, 40'd99302, 32'd10041}},
      '{16'd0,     32'd10050,     1'b1, '{msd_pkg::KIND_START, 40'd0, 32'd10050}},
      '{16'd0,     32'hFFFF_FFF0, 1'b1, '{msd_pkg::KIND_END, 40'd32768, 32'hFFFF_FFF0}},
      '{16'd5000,  32'hFFFF_FFF8, 1'b1, '{msd_pkg::KIND_START, 40'd0, 32'hFFFF_FFF8}},
      '{16'd5000,  32'd10000,     1'b1, '{msd_pkg::KIND_END, 40'd5000, 32'd10000}},
      '{16'd5000,  32'hFFFF_FFFF, 1'b0, NO_EVENT},
      '{16'h7FFF, 32'hFFFF_FFFF, 1'b1, '{msd_pkg::KIND_START, 40'd0, 32'hFFFF_FFFF}},
      '{16'h8000, 32'd0,         1'b0, NO_EVENT},
      '{16'h8001, 32'd5,         1'b0, NO_EVENT}
    };
    thr_set = '{16'd0, 16'hFFFF, 16'd1000, 16'd300, 16'd0, 16'd5000};
    tmo_set = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd50, 32'd0, 32'd200};
    thr_set[4] = msd_pkg::THR_W'($urandom_range(0, 8000));
    tmo_set[4] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      offer_sample(rows[r].sample, rows[r].stamp, rows[r].typed, rows[r].want);
    end
    clock_ms = 32'd5;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_setting(msd_pkg::CFG_THRESHOLD, {16'd0, thr_set[p]});
      write_setting(msd_pkg::CFG_TIMEOUT, tmo_set[p]);
      burst_left = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        offer_random_sample();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/msd_pkg.sv
rtl/msd_step.sv
rtl/motion_session_detector.sv
verif/testbench.sv
